/* hw/rtl/bslp_pkg.sv */
// Shared types, character codes and key text for the battery status line parser.
// Used by bslp_front, bslp_back and battery_status_line_parser; depends on nothing.
package bslp_pkg;

    // Depth of the byte queue between the front and back parts (power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Character codes the parser looks for.
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_BRACE = 8'h7B;

    // Line format register values.
    localparam logic FMT_COMMA = 1'b0;
    localparam logic FMT_KEYED = 1'b1;

    // Key numbers of the keyed format, in the order they appear on a line.
    localparam logic [2:0] KEY_CODE     = 3'd0;
    localparam logic [2:0] KEY_CAPACITY = 3'd1;
    localparam logic [2:0] KEY_TEMP     = 3'd2;
    localparam logic [2:0] KEY_CHG      = 3'd3;
    localparam logic [2:0] KEY_CYCLE    = 3'd4;

    // Largest magnitude the number accumulator holds.
    localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;

    // Header of the comma format, first character in the top byte.
    localparam int         HEAD_LEN  = 5;
    localparam logic [39:0] HEAD_TEXT = "{OK},";

    // Key text, left aligned and padded with spaces to 15 characters.
    localparam logic [119:0] TXT_CODE     = "\"code\":        ";
    localparam logic [119:0] TXT_CAPACITY = "\"capacity\":    ";
    localparam logic [119:0] TXT_TEMP     = "\"temp\":        ";
    localparam logic [119:0] TXT_CHG      = "\"chg_state\":   ";
    localparam logic [119:0] TXT_CYCLE    = "\"charge_cycle\":";

    // One classified byte as it travels through the queue.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_nl;
        logic       is_comma;
        logic       is_minus;
        logic       is_brace;
    } t_item;

    // One finished line record.
    typedef struct packed {
        logic        parse_ok;
        logic [7:0]  charge_percent;
        logic [15:0] temperature_tenths;
        logic        charging;
        logic [15:0] charge_cycles;
    } t_result;

    // Character of the comma format header at a position below HEAD_LEN.
    function automatic logic [7:0] head_char(input logic [2:0] pos);
        logic [5:0] bit_hi;
        bit_hi = 6'd39 - {pos, 3'b000};
        return HEAD_TEXT[bit_hi -: 8];
    endfunction

    // Length of a key including quotes and colon.
    function automatic logic [3:0] key_len(input logic [2:0] key);
        logic [3:0] len;
        unique case (key)
            KEY_CODE:     len = 4'd7;
            KEY_CAPACITY: len = 4'd11;
            KEY_TEMP:     len = 4'd7;
            KEY_CHG:      len = 4'd12;
            KEY_CYCLE:    len = 4'd15;
            default:      len = 4'd0;
        endcase
        return len;
    endfunction

    // Character of a key at a position below its length.
    function automatic logic [7:0] key_char(input logic [2:0] key, input logic [3:0] pos);
        logic [119:0] txt;
        logic [6:0]   bit_hi;
        unique case (key)
            KEY_CODE:     txt = TXT_CODE;
            KEY_CAPACITY: txt = TXT_CAPACITY;
            KEY_TEMP:     txt = TXT_TEMP;
            KEY_CHG:      txt = TXT_CHG;
            KEY_CYCLE:    txt = TXT_CYCLE;
            default:      txt = '0;
        endcase
        bit_hi = 7'd119 - {pos, 3'b000};
        return txt[bit_hi -: 8];
    endfunction

endpackage

/* hw/rtl/battery_status_line_parser.sv */
// A newline beat is written into the byte queue, then its record is registered once the parser takes it.
// Throughput: one byte per cycle unless a record stalls; bslp_back parses one byte a cycle.
// A two-beat queue separates byte intake from parsing, so input is taken while a record waits.
// Reset (synchronous, active low) clears the parser, the stored fields and line_format.
// Top level of the battery status line parser.
// Depends on bslp_pkg, bslp_front and bslp_back.
module battery_status_line_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Received bytes
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    // Line records
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_parse_ok,
    output logic [7:0]         o_charge_percent,
    output logic signed [15:0] o_temperature_tenths,
    output logic               o_charging,
    output logic [15:0]        o_charge_cycles,
    // Configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_line_format
);

    logic              r_line_format;
    logic              w_item_valid;
    logic              w_item_take;
    bslp_pkg::t_item   w_item;
    bslp_pkg::t_result w_result;

    // Line format register; every write beat is taken at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_format <= bslp_pkg::FMT_COMMA;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_format <= i_cfg_line_format;
        end
    end

    bslp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .o_stall      (o_stall),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_take  (w_item_take)
    );

    bslp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_format (r_line_format),
        .i_item_valid  (w_item_valid),
        .i_item        (w_item),
        .o_item_take   (w_item_take),
        .o_valid       (o_valid),
        .o_result      (w_result),
        .i_stall       (i_stall)
    );

    // Record fields onto their ports.
    assign o_parse_ok           = w_result.parse_ok;
    assign o_charge_percent     = w_result.charge_percent;
    assign o_temperature_tenths = signed'(w_result.temperature_tenths);
    assign o_charging           = w_result.charging;
    assign o_charge_cycles      = w_result.charge_cycles;

endmodule

/* hw/rtl/bslp_front.sv */
// Front part: accepts received bytes, classifies them and holds them in a short queue.
// Depends on bslp_pkg for the item type, queue depth and character codes.
module bslp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    output logic               o_stall,
    output logic               o_item_valid,
    output bslp_pkg::t_item    o_item,
    input  logic               i_item_take
);

    bslp_pkg::t_item                  r_mem [bslp_pkg::QUEUE_DEPTH];
    logic [bslp_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [bslp_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [bslp_pkg::QUEUE_AW:0]      r_count;
    logic [bslp_pkg::QUEUE_AW:0]      n_count;
    bslp_pkg::t_item                  w_class;
    logic                             w_push;
    logic                             w_pop;

    // Classify the incoming byte once so the back part only tests flags.
    always_comb begin
        w_class          = '0;
        w_class.rx_byte  = i_rx_byte;
        w_class.is_digit = (i_rx_byte >= bslp_pkg::CHAR_ZERO) &&
                           (i_rx_byte <= bslp_pkg::CHAR_NINE);
        w_class.digit    = i_rx_byte[3:0];
        w_class.is_nl    = (i_rx_byte == bslp_pkg::CHAR_NL);
        w_class.is_comma = (i_rx_byte == bslp_pkg::CHAR_COMMA);
        w_class.is_minus = (i_rx_byte == bslp_pkg::CHAR_MINUS);
        w_class.is_brace = (i_rx_byte == bslp_pkg::CHAR_BRACE);
    end

    // Queue handshake: full queue stalls the sender, the head is always visible.
    assign o_stall      = (r_count == (bslp_pkg::QUEUE_AW + 1)'(bslp_pkg::QUEUE_DEPTH));
    assign w_push       = i_valid && !o_stall;
    assign o_item_valid = (r_count != '0);
    assign w_pop        = i_item_take && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

endmodule

/* hw/rtl/bslp_back.sv */
// Back part: runs the line parser on queued bytes and registers one record per newline.
// Depends on bslp_pkg for the item and record types, key text and constants.
module bslp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_line_format,
    input  logic               i_item_valid,
    input  bslp_pkg::t_item    i_item,
    output logic               o_item_take,
    output logic               o_valid,
    output bslp_pkg::t_result  o_result,
    input  logic               i_stall
);

    // Parser phase codes.
    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_SOC   = 4'd1;
    localparam logic [3:0] PH_TEMP  = 4'd2;
    localparam logic [3:0] PH_CHG   = 4'd3;
    localparam logic [3:0] PH_COMMA = 4'd4;
    localparam logic [3:0] PH_CYC   = 4'd5;
    localparam logic [3:0] PH_KEY0  = 4'd6;
    localparam logic [3:0] PH_KEY4  = 4'd10;
    localparam logic [3:0] PH_DONE  = 4'd15;

    logic [3:0]        r_phase,     n_phase;
    logic [3:0]        r_key_pos,   n_key_pos;
    logic [30:0]       r_acc,       n_acc;
    logic              r_neg,       n_neg;
    logic              r_digit_seen, n_digit_seen;
    logic              r_failed,    n_failed;
    logic [7:0]        r_charge,    n_charge;
    logic [15:0]       r_temp,      n_temp;
    logic              r_charging,  n_charging;
    logic [15:0]       r_cycles,    n_cycles;
    logic              r_out_valid;
    bslp_pkg::t_result r_result;

    logic              w_out_free;
    logic              w_line_ok;
    logic [34:0]       w_mul10;
    logic [34:0]       w_sum;
    logic [30:0]       w_acc_digit;
    logic [15:0]       w_temp_plain;
    logic [15:0]       w_temp_keyed;
    logic [7:0]        w_charge_keyed;
    logic [15:0]       w_cycles_keyed;
    logic [3:0]        w_key_off;
    logic [2:0]        w_key;

    // A byte leaves the queue unless it ends a line while the record slot is busy.
    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_item_take = i_item_valid && (!i_item.is_nl || w_out_free);

    // Decimal accumulate with saturation, shared by both formats.
    assign w_mul10     = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
    assign w_sum       = w_mul10 + {31'd0, i_item.digit};
    assign w_acc_digit = (w_sum[34:31] != 4'd0) ? bslp_pkg::ACC_MAX : w_sum[30:0];

    // Field values as they are stored when a number ends.
    assign w_temp_plain = (r_acc > 31'd32767) ? 16'h7FFF : r_acc[15:0];
    always_comb begin
        if (r_neg) begin
            w_temp_keyed = (w_mul10 > 35'd32768) ? 16'h8000 : 16'(16'd0 - w_mul10[15:0]);
        end else begin
            w_temp_keyed = (w_mul10 > 35'd32767) ? 16'h7FFF : w_mul10[15:0];
        end
    end
    assign w_charge_keyed = r_neg ? 8'(8'd0 - r_acc[7:0]) : r_acc[7:0];
    assign w_cycles_keyed = r_neg ? 16'(16'd0 - r_acc[15:0]) : r_acc[15:0];
    assign w_key_off      = r_phase - PH_KEY0;
    assign w_key          = w_key_off[2:0];

    // Parser step for one byte, then the end of line handling.
    always_comb begin
        n_phase      = r_phase;
        n_key_pos    = r_key_pos;
        n_acc        = r_acc;
        n_neg        = r_neg;
        n_digit_seen = r_digit_seen;
        n_failed     = r_failed;
        n_charge     = r_charge;
        n_temp       = r_temp;
        n_charging   = r_charging;
        n_cycles     = r_cycles;
        w_line_ok    = 1'b0;

        if (o_item_take) begin
            if (!r_failed && (r_phase != PH_DONE)) begin
                priority if (r_phase == PH_START) begin
                    // Line opening: header text or opening brace.
                    if (i_line_format == bslp_pkg::FMT_COMMA) begin
                        if ((r_key_pos < 4'(bslp_pkg::HEAD_LEN)) &&
                            (bslp_pkg::head_char(r_key_pos[2:0]) == i_item.rx_byte)) begin
                            if (r_key_pos == 4'(bslp_pkg::HEAD_LEN - 1)) begin
                                n_phase      = PH_SOC;
                                n_key_pos    = '0;
                                n_acc        = '0;
                                n_neg        = 1'b0;
                                n_digit_seen = 1'b0;
                            end else begin
                                n_key_pos = r_key_pos + 4'd1;
                            end
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else begin
                        if (i_item.is_brace) begin
                            n_phase      = PH_KEY0;
                            n_key_pos    = '0;
                            n_acc        = '0;
                            n_neg        = 1'b0;
                            n_digit_seen = 1'b0;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                end else if ((r_phase == PH_SOC) || (r_phase == PH_TEMP) ||
                             (r_phase == PH_CYC)) begin
                    // Comma format numeric fields.
                    if (i_item.is_digit) begin
                        n_acc        = w_acc_digit;
                        n_digit_seen = 1'b1;
                    end else if (r_phase == PH_SOC) begin
                        n_charge = r_acc[7:0];
                        if (!r_digit_seen) begin
                            n_failed = 1'b1;
                        end else begin
                            n_phase      = PH_TEMP;
                            n_acc        = '0;
                            n_neg        = 1'b0;
                            n_digit_seen = 1'b0;
                        end
                    end else if (r_phase == PH_TEMP) begin
                        n_temp = w_temp_plain;
                        if (!r_digit_seen || !i_item.is_comma) begin
                            n_failed = 1'b1;
                        end else begin
                            n_phase      = PH_CHG;
                            n_acc        = '0;
                            n_neg        = 1'b0;
                            n_digit_seen = 1'b0;
                        end
                    end else begin
                        n_cycles = r_acc[15:0];
                        if (!r_digit_seen) begin
                            n_failed = 1'b1;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end else if (r_phase == PH_CHG) begin
                    // Charging flag is a single 0 or 1.
                    if (i_item.is_digit && (i_item.digit <= 4'd1)) begin
                        n_acc   = {27'd0, i_item.digit};
                        n_phase = PH_COMMA;
                    end else begin
                        n_failed = 1'b1;
                    end
                end else if (r_phase == PH_COMMA) begin
                    if (i_item.is_comma) begin
                        n_charging   = r_acc[0];
                        n_phase      = PH_CYC;
                        n_acc        = '0;
                        n_neg        = 1'b0;
                        n_digit_seen = 1'b0;
                    end else begin
                        n_failed = 1'b1;
                    end
                end else if ((r_phase >= PH_KEY0) && (r_phase <= PH_KEY4)) begin
                    // Keyed format: match the key text, then read a signed number.
                    if (r_key_pos < bslp_pkg::key_len(w_key)) begin
                        if (bslp_pkg::key_char(w_key, r_key_pos) == i_item.rx_byte) begin
                            n_key_pos = r_key_pos + 4'd1;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else if (i_item.is_digit) begin
                        n_acc        = w_acc_digit;
                        n_digit_seen = 1'b1;
                    end else if (i_item.is_minus && !r_digit_seen && !r_neg) begin
                        n_neg = 1'b1;
                    end else if (!r_digit_seen) begin
                        n_failed = 1'b1;
                    end else begin
                        unique case (w_key)
                            bslp_pkg::KEY_CODE: begin
                                if (r_acc != '0) begin
                                    n_failed = 1'b1;
                                end
                            end
                            bslp_pkg::KEY_CAPACITY: n_charge   = w_charge_keyed;
                            bslp_pkg::KEY_TEMP:     n_temp     = w_temp_keyed;
                            bslp_pkg::KEY_CHG:      n_charging = (r_acc != '0);
                            bslp_pkg::KEY_CYCLE:    n_cycles   = w_cycles_keyed;
                            default:                n_failed   = 1'b1;
                        endcase
                        if (w_key == bslp_pkg::KEY_CYCLE) begin
                            n_phase = PH_DONE;
                        end else if (!n_failed) begin
                            n_phase      = r_phase + 4'd1;
                            n_key_pos    = '0;
                            n_acc        = '0;
                            n_neg        = 1'b0;
                            n_digit_seen = 1'b0;
                        end
                    end
                end else begin
                    n_failed = 1'b1;
                end
            end

            // Newline: report the line, then start over.
            if (i_item.is_nl) begin
                w_line_ok    = !n_failed && (n_phase == PH_DONE);
                n_phase      = PH_START;
                n_key_pos    = '0;
                n_acc        = '0;
                n_neg        = 1'b0;
                n_digit_seen = 1'b0;
                n_failed     = 1'b0;
            end
        end
    end

    // Parser state and stored fields.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_key_pos    <= '0;
            r_acc        <= '0;
            r_neg        <= 1'b0;
            r_digit_seen <= 1'b0;
            r_failed     <= 1'b0;
            r_charge     <= '0;
            r_temp       <= '0;
            r_charging   <= 1'b0;
            r_cycles     <= '0;
        end else begin
            r_phase      <= n_phase;
            r_key_pos    <= n_key_pos;
            r_acc        <= n_acc;
            r_neg        <= n_neg;
            r_digit_seen <= n_digit_seen;
            r_failed     <= n_failed;
            r_charge     <= n_charge;
            r_temp       <= n_temp;
            r_charging   <= n_charging;
            r_cycles     <= n_cycles;
        end
    end

    // Record output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_item_take && i_item.is_nl) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take && i_item.is_nl) begin
            r_result.parse_ok           <= w_line_ok;
            r_result.charge_percent     <= n_charge;
            r_result.temperature_tenths <= n_temp;
            r_result.charging           <= n_charging;
            r_result.charge_cycles      <= n_cycles;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

/* verif/bslp_checker.sv */
// Checker for the battery status line parser: watches the byte, record and
// configuration channels, predicts every line record and compares it field by field.
// Depends on bslp_pkg for the record type, format values, key numbers and character codes.
module bslp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_byte,
    input  logic        i_rec_valid,
    input  logic        i_rec_stall,
    input  logic        i_parse_ok,
    input  logic [7:0]  i_charge_percent,
    input  logic [15:0] i_temperature_tenths,
    input  logic        i_charging,
    input  logic [15:0] i_charge_cycles,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_line_format,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bslp_pkg::*;

    // Where the parser stands within the current line.
    localparam logic [3:0] LN_IDLE      = 4'd0;
    localparam logic [3:0] LN_CHARGE    = 4'd1;
    localparam logic [3:0] LN_TEMP      = 4'd2;
    localparam logic [3:0] LN_STATE     = 4'd3;
    localparam logic [3:0] LN_SEP       = 4'd4;
    localparam logic [3:0] LN_CYCLES    = 4'd5;
    localparam logic [3:0] LN_KEY_FIRST = 4'd6;
    localparam logic [3:0] LN_KEY_LAST  = 4'd10;
    localparam logic [3:0] LN_END       = 4'd15;

    localparam logic [31:0] MAG_LIMIT = 32'h7FFF_FFFF;

    // Predicted parser state and the configured format.
    logic        fmt_sel;
    logic [3:0]  line_pos;
    logic [3:0]  text_idx;
    logic [31:0] mag;
    logic        minus_seen;
    logic        digits_seen;
    logic        line_bad;
    logic [7:0]  rec_charge;
    logic [15:0] rec_temp;
    logic        rec_chg;
    logic [15:0] rec_cycles;

    // Records predicted but not yet seen on the output.
    t_result     pending_records[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic string key_text(input logic [2:0] k);
        case (k)
            KEY_CODE:     return "\"code\":";
            KEY_CAPACITY: return "\"capacity\":";
            KEY_TEMP:     return "\"temp\":";
            KEY_CHG:      return "\"chg_state\":";
            default:      return "\"charge_cycle\":";
        endcase
    endfunction

    function automatic void start_number();
        mag         = '0;
        minus_seen  = 1'b0;
        digits_seen = 1'b0;
    endfunction

    function automatic void start_line();
        line_pos = LN_IDLE;
        text_idx = '0;
        start_number();
        line_bad = 1'b0;
    endfunction

    function automatic logic [15:0] clamp_s16(input longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    // Adds a digit (or a leading minus where allowed); returns 1 when the byte was taken.
    function automatic logic take_digit(input logic [7:0] c, input logic sign_ok);
        logic [63:0] grown;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            grown = 64'(mag) * 64'd10 + 64'(c - CHAR_ZERO);
            mag = (grown > 64'(MAG_LIMIT)) ? MAG_LIMIT : grown[31:0];
            digits_seen = 1'b1;
            return 1'b1;
        end
        if (sign_ok && c == CHAR_MINUS && !digits_seen && !minus_seen) begin
            minus_seen = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Comma list fields after the header.
    function automatic void comma_byte(input logic [7:0] c);
        if (line_pos == LN_CHARGE || line_pos == LN_TEMP || line_pos == LN_CYCLES) begin
            if (take_digit(c, 1'b0)) return;
            if (line_pos == LN_CHARGE) begin
                rec_charge = mag[7:0];
                if (!digits_seen) line_bad = 1'b1;
                else begin
                    line_pos = LN_TEMP;
                    start_number();
                end
            end else if (line_pos == LN_TEMP) begin
                // Temperature is already in tenths; only the terminator must be a comma.
                rec_temp = clamp_s16(longint'(mag));
                if (!digits_seen || c != CHAR_COMMA) line_bad = 1'b1;
                else begin
                    line_pos = LN_STATE;
                    start_number();
                end
            end else begin
                rec_cycles = mag[15:0];
                if (!digits_seen) line_bad = 1'b1;
                else line_pos = LN_END;
            end
        end else if (line_pos == LN_STATE) begin
            if (c == CHAR_ZERO || c == CHAR_ZERO + 8'd1) begin
                mag      = 32'(c - CHAR_ZERO);
                line_pos = LN_SEP;
            end else begin
                line_bad = 1'b1;
            end
        end else begin
            if (c == CHAR_COMMA) begin
                rec_chg  = mag[0];
                line_pos = LN_CYCLES;
                start_number();
            end else begin
                line_bad = 1'b1;
            end
        end
    endfunction

    // Keyed list: match the key text exactly, then read a possibly negative number.
    function automatic void keyed_byte(input logic [7:0] c);
        logic [2:0] k;
        string      txt;
        longint     v;
        k   = 3'(line_pos - LN_KEY_FIRST);
        txt = key_text(k);
        if (int'(text_idx) < txt.len()) begin
            if (txt[text_idx] == c) text_idx = text_idx + 4'd1;
            else line_bad = 1'b1;
            return;
        end
        if (take_digit(c, 1'b1)) return;
        if (!digits_seen) begin
            line_bad = 1'b1;
            return;
        end
        v = longint'(mag);
        if (minus_seen) v = -v;
        case (k)
            KEY_CODE: begin
                if (v != 0) begin
                    line_bad = 1'b1;
                    return;
                end
            end
            KEY_CAPACITY: rec_charge = v[7:0];
            KEY_TEMP:     rec_temp = clamp_s16(v * 10);
            KEY_CHG:      rec_chg = (v != 0);
            default: begin
                rec_cycles = v[15:0];
                line_pos   = LN_END;
                return;
            end
        endcase
        line_pos = line_pos + 4'd1;
        text_idx = '0;
        start_number();
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        string head;
        head = "{OK},";
        if (line_bad || line_pos == LN_END) return;
        if (line_pos == LN_IDLE) begin
            // The format is only looked at while the line opening is being matched.
            if (fmt_sel == FMT_COMMA) begin
                if (int'(text_idx) < head.len() && head[text_idx] == c) begin
                    text_idx = text_idx + 4'd1;
                    if (int'(text_idx) == head.len()) begin
                        line_pos = LN_CHARGE;
                        text_idx = '0;
                        start_number();
                    end
                end else begin
                    line_bad = 1'b1;
                end
            end else begin
                if (c == CHAR_BRACE) begin
                    line_pos = LN_KEY_FIRST;
                    text_idx = '0;
                    start_number();
                end else begin
                    line_bad = 1'b1;
                end
            end
        end else if (line_pos <= LN_CYCLES) begin
            comma_byte(c);
        end else if (line_pos <= LN_KEY_LAST) begin
            keyed_byte(c);
        end else begin
            line_bad = 1'b1;
        end
    endfunction

    // Track every beat at the rising edge: predict on bytes, compare on records.
    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        logic    wrong;
        if (!i_rst_n) begin
            fmt_sel    = FMT_COMMA;
            start_line();
            rec_charge = '0;
            rec_temp   = '0;
            rec_chg    = 1'b0;
            rec_cycles = '0;
            pending_records.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) fmt_sel = i_cfg_line_format;

            if (i_byte_valid && !i_byte_stall) begin
                parse_byte(i_byte);
                if (i_byte == CHAR_NL) begin
                    want.parse_ok           = !line_bad && line_pos == LN_END;
                    want.charge_percent     = rec_charge;
                    want.temperature_tenths = rec_temp;
                    want.charging           = rec_chg;
                    want.charge_cycles      = rec_cycles;
                    pending_records.push_back(want);
                    start_line();
                end
            end

            if (i_rec_valid && !i_rec_stall) begin
                got.parse_ok           = i_parse_ok;
                got.charge_percent     = i_charge_percent;
                got.temperature_tenths = i_temperature_tenths;
                got.charging           = i_charging;
                got.charge_cycles      = i_charge_cycles;
                if (pending_records.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: record beat with none expected: ok=%0d soc=%0d",
                                 $time, got.parse_ok, got.charge_percent);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want  = pending_records.pop_front();
                    wrong = (got.parse_ok !== want.parse_ok)
                          || (got.charge_percent !== want.charge_percent)
                          || (got.temperature_tenths !== want.temperature_tenths)
                          || (got.charging !== want.charging)
                          || (got.charge_cycles !== want.charge_cycles);
                    if (wrong) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: record mismatch, expected ok=%0d soc=%0d temp=%0d chg=%0d cyc=%0d",
                                     $time, want.parse_ok, want.charge_percent,
                                     $signed(want.temperature_tenths), want.charging,
                                     want.charge_cycles);
                            $display("%0t:                  actual ok=%0d soc=%0d temp=%0d chg=%0d cyc=%0d",
                                     $time, got.parse_ok, got.charge_percent,
                                     $signed(got.temperature_tenths), got.charging,
                                     got.charge_cycles);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = pending_records.size();
    end

endmodule

/* verif/tb.sv */
// Top of the battery status line parser testbench: clock, reset, byte and record traffic,
// format writes and the verdict. Depends on bslp_pkg, bslp_checker and
// battery_status_line_parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bslp_pkg::*;

    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         HOLD_CYCLES   = 200;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         SEG_BYTES     = 100;
    localparam int         SEG_LINES     = 6;
    localparam logic [7:0] CHAR_CLOSE    = 8'h7D;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  rx_data    = 8'h00;
    logic        rec_valid;
    logic        rec_stall  = 1'b0;
    logic        parse_ok;
    logic [7:0]  charge_percent;
    logic signed [15:0] temperature_tenths;
    logic        charging;
    logic [15:0] charge_cycles;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic        cfg_fmt    = 1'b0;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_go     = 1'b0;
    logic [7:0]  line_bytes[$];

    battery_status_line_parser dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_valid              (byte_valid),
        .o_stall              (byte_stall),
        .i_rx_byte            (rx_data),
        .o_valid              (rec_valid),
        .i_stall              (rec_stall),
        .o_parse_ok           (parse_ok),
        .o_charge_percent     (charge_percent),
        .o_temperature_tenths (temperature_tenths),
        .o_charging           (charging),
        .o_charge_cycles      (charge_cycles),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_line_format    (cfg_fmt)
    );

    bslp_checker chk (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_byte_valid         (byte_valid),
        .i_byte_stall         (byte_stall),
        .i_byte               (rx_data),
        .i_rec_valid          (rec_valid),
        .i_rec_stall          (rec_stall),
        .i_parse_ok           (parse_ok),
        .i_charge_percent     (charge_percent),
        .i_temperature_tenths (temperature_tenths),
        .i_charging           (charging),
        .i_charge_cycles      (charge_cycles),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_line_format    (cfg_fmt),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    always #1 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Record side: random stall, or one long hold-off when the sender asks for it.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                rec_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rec_stall = ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Offers one byte beat, starting at a falling edge and returning at one.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_valid = 1'b1;
        rx_data    = b;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
    endtask

    task automatic add_byte(input logic [7:0] b);
        line_bytes.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    task automatic send_text(input string s);
        line_bytes.delete();
        add_text(s);
        send_line();
    endtask

    // Sender pauses until every expected record has come out.
    task automatic wait_drained();
        byte_valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // Format writes happen only once every expected record is out and the byte queue has emptied.
    task automatic set_format(input logic f);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_fmt   = f;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic string rand_number(input bit sign_ok);
        string s;
        int    n;
        case ($urandom_range(0, 9))
            0, 1, 2: s = $sformatf("%0d", $urandom_range(0, 100));
            3, 4, 5: s = $sformatf("%0d", $urandom_range(0, 70000));
            6, 7:    s = $sformatf("%0d", $urandom());
            default: begin
                // Long digit strings drive the accumulator into saturation.
                s = "";
                n = $urandom_range(10, 14);
                repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            end
        endcase
        if (sign_ok && $urandom_range(0, 3) == 0) s = {"-", s};
        return s;
    endfunction

    // Any byte that neither extends a number nor ends the line.
    function automatic logic [7:0] rand_filler();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_NL);
        return b;
    endfunction

    task automatic build_comma();
        add_text("{OK},");
        add_text(rand_number(1'b0));
        add_byte(($urandom_range(0, 3) == 0) ? rand_filler() : CHAR_COMMA);
        add_text(rand_number(1'b0));
        add_byte(CHAR_COMMA);
        add_byte(CHAR_ZERO + 8'($urandom_range(0, 1)));
        add_byte(CHAR_COMMA);
        add_text(rand_number(1'b0));
        if ($urandom_range(0, 3) == 0) add_byte(rand_filler());
        add_byte(CHAR_NL);
    endtask

    task automatic build_keyed();
        logic [2:0] k;
        add_byte(CHAR_BRACE);
        for (int i = 0; i < 5; i++) begin
            k = 3'(i);
            for (int p = 0; p < int'(key_len(k)); p++) add_byte(key_char(k, 4'(p)));
            case (k)
                KEY_CODE: begin
                    if ($urandom_range(0, 7) == 0) add_text(rand_number(1'b1));
                    else add_text("0");
                end
                KEY_TEMP: begin
                    if ($urandom_range(0, 2) != 0)
                        add_text($sformatf("%0d", int'($urandom_range(0, 140)) - 40));
                    else
                        add_text(rand_number(1'b1));
                end
                KEY_CHG: begin
                    if ($urandom_range(0, 3) != 0)
                        add_text($sformatf("%0d", $urandom_range(0, 2)));
                    else
                        add_text(rand_number(1'b1));
                end
                default: add_text(rand_number(1'b1));
            endcase
            // One byte after each value is skipped, whatever it is.
            if ($urandom_range(0, 4) == 0) add_byte(rand_filler());
            else add_byte((k == KEY_CYCLE) ? CHAR_CLOSE : CHAR_COMMA);
        end
        if ($urandom_range(0, 3) == 0) add_byte(rand_filler());
        add_byte(CHAR_NL);
    endtask

    // Mostly well-formed lines of the set format, plus noise, other-format and damaged lines.
    task automatic make_line(input logic f);
        int pick;
        int pos;
        int n;
        line_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            n = $urandom_range(1, 30);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
            add_byte(CHAR_NL);
            return;
        end
        if ((pick < 12) != (f == FMT_KEYED)) build_keyed();
        else build_comma();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            pos = $urandom_range(0, line_bytes.size() - 1);
            line_bytes[pos] = 8'($urandom_range(0, 255));
        end else if (pick < 17) begin
            pos = $urandom_range(0, line_bytes.size() - 2);
            line_bytes.delete(pos);
        end
    endtask

    // One random stretch in one format, with a long receiver hold-off and a full drain.
    task automatic run_segment(input logic f);
        int nl_sent   = 0;
        int byte_sent = 0;
        bit held      = 1'b0;
        bit paused    = 1'b0;
        set_format(f);
        while (byte_sent < SEG_BYTES || nl_sent < SEG_LINES) begin
            if (!held && nl_sent >= 1) begin
                hold_go = 1'b1;
                held    = 1'b1;
            end
            if (!paused && nl_sent >= 3) begin
                wait_drained();
                paused = 1'b1;
            end
            make_line(f);
            foreach (line_bytes[i]) if (line_bytes[i] == CHAR_NL) nl_sent++;
            byte_sent += line_bytes.size();
            send_line();
        end
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 26;
        rx_idle_pct = 60;

        // Comma list cases with the reset format.
        send_text("{OK},100,253,1,512\n");
        send_text("{OK},99999999999;99999,0,4294967296X\n");
        send_text("{OK},,5,1,2\n");
        send_text("{OK},7,25\n");
        send_text("{OK},42,-5,1,1\n");
        send_text("{OK},5,12,2,3\n");
        send_text("{OK},0,0,0,0\n");
        line_bytes.delete();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("{OK}\n");
        send_line();

        // Keyed list cases.
        set_format(FMT_KEYED);
        send_text({"{\"code\":0,\"capacity\":87,\"temp\":-4000,",
                   "\"chg_state\":3,\"charge_cycle\":70000}\n"});
        send_text({"{\"code\":1,\"capacity\":50,\"temp\":20,",
                   "\"chg_state\":0,\"charge_cycle\":5}\n"});
        send_text("{\"code\":0,\"capacity\":-,\"temp\":1}\n");
        send_text({"{\"code\":-0,\"capacity\":300,\"temp\":5000,",
                   "\"chg_state\":0,\"charge_cycle\":1\n"});
        send_text("{\"cod\":0}\n");
        send_text("{\"code\":0,\"capacity\":--5}\n");
        send_text({"{\"code\":0,\"capacity\":-20,\"temp\":99999999999,",
                   "\"chg_state\":-1,\"charge_cycle\":-1}\n"});
        send_text({"{\"code\":0,\"capacity\":1,\"temp\":-99999999999,",
                   "\"chg_state\":0,\"charge_cycle\":0}junk\n"});
        send_text("{OK},1,2,1,3\n");

        // Random traffic under three idling patterns.
        run_segment(FMT_COMMA);
        run_segment(FMT_KEYED);
        tx_idle_pct = 60;
        rx_idle_pct = 26;
        run_segment(FMT_KEYED);
        run_segment(FMT_COMMA);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_segment(FMT_COMMA);
        run_segment(FMT_KEYED);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

/* battery_status_line_parser.f */
hw/rtl/bslp_pkg.sv
hw/rtl/bslp_front.sv
hw/rtl/bslp_back.sv
hw/rtl/battery_status_line_parser.sv
verif/bslp_checker.sv
verif/tb.sv
